// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Needs nothing else; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define CHP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked property that also holds across reset.
`define CHP_ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/chp_pkg.sv =====
// Shared constants, types and saturating helpers for the hull pruner.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package chp_pkg;

  localparam int HULL_DEPTH = 64;
  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 24;
  localparam int SUM_W      = SAMPLE_W + COUNT_W;
  localparam int BND_W      = 32;
  localparam int COST_W     = 64;
  localparam int PROD_W     = 2 * SUM_W;
  localparam int IDX_W      = $clog2(HULL_DEPTH);
  localparam int ENT_W      = $clog2(HULL_DEPTH + 1);
  localparam int RAM_DEPTH  = 2 ** (IDX_W + 1);
  localparam int ENTRY_W    = COUNT_W + BND_W + SUM_W;
  localparam int STEP_W     = $clog2(PROD_W + 1);

  localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [BND_W-1:0]  BND_MAX  = {1'b0, {(BND_W-1){1'b1}}};
  localparam logic signed [BND_W-1:0]  BND_MIN  = {1'b1, {(BND_W-1){1'b0}}};
  localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};

  typedef enum logic {
    OP_MEAN,
    OP_SQDIV
  } arith_op_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_DIV,
    PH_FIX
  } arith_phase_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_POP_LD,
    ST_POP_GO,
    ST_POP_DIV,
    ST_EMPTY_GO,
    ST_EMPTY_DIV,
    ST_PUSH,
    ST_NC_GO,
    ST_NC_WAIT,
    ST_C_RD,
    ST_C_LD,
    ST_C_T1GO,
    ST_C_T1,
    ST_C_T2GO,
    ST_C_T2,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic                start;
    arith_op_t           op;
    logic [SUM_W-1:0]    opa;
    logic [COUNT_W-1:0]  dvs;
  } arith_req_t;

  typedef struct packed {
    logic                done;
    logic [COST_W-1:0]   result;
  } arith_rsp_t;

  typedef struct packed {
    logic [COUNT_W-1:0]       pos;
    logic signed [BND_W-1:0]  bnd;
    logic signed [SUM_W-1:0]  psum;
  } entry_t;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] w;
    w = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (w[SUM_W] != w[SUM_W-1]) return w[SUM_W] ? SUM_MIN : SUM_MAX;
    return w[SUM_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_neg(input logic signed [SUM_W-1:0] a);
    if (a == SUM_MIN) return SUM_MAX;
    return -a;
  endfunction

  // a - b as a + (-b), both steps saturating
  function automatic logic signed [SUM_W-1:0] sat_sub(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
    return sat_add(a, sat_neg(b));
  endfunction

  function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] a);
    return a[SUM_W-1] ? (SUM_W'(0) - a) : a;
  endfunction

  // ring position of logical slot k
  function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] k);
    logic [IDX_W:0] w;
    w = {1'b0, base} + {1'b0, k};
    if (w >= (IDX_W+1)'(HULL_DEPTH)) w = w - (IDX_W+1)'(HULL_DEPTH);
    return w[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/chp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module chp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== design/chp_arith.sv =====
// Shared iterative unit: floor mean in Q16.16, and floor(m*m/d) saturated.
// Shift-add square then restoring divide, one bit per cycle. Uses chp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chp_arith (
  input  logic                clk,
  input  logic                rst,
  input  chp_pkg::arith_req_t req,
  output chp_pkg::arith_rsp_t rsp
);

  localparam int QM_W = chp_pkg::SUM_W + 8;

  chp_pkg::arith_phase_t phase, phase_next;
  chp_pkg::arith_op_t    op;
  logic                  neg;
  logic [chp_pkg::SUM_W-1:0]   mcand;
  logic [chp_pkg::SUM_W-1:0]   mplier;
  logic [chp_pkg::PROD_W-1:0]  acc;
  logic [chp_pkg::COUNT_W-1:0] rem;
  logic [chp_pkg::COUNT_W-1:0] dvs;
  logic [chp_pkg::STEP_W-1:0]  steps;
  logic [chp_pkg::COST_W-1:0]  result;
  logic                        done;

  logic [chp_pkg::COUNT_W:0]   rsh, diffr;
  logic                        ge;
  logic [chp_pkg::PROD_W-1:0]  acc_mul;
  logic [QM_W-1:0]             qm;
  logic [QM_W:0]               qmag;
  logic [chp_pkg::BND_W-1:0]   mean_val;
  logic [chp_pkg::COST_W-1:0]  sq_val;

  always_comb begin
    phase_next = phase;
    case (phase)
      chp_pkg::PH_IDLE: begin
        if (req.start) phase_next = (req.op == chp_pkg::OP_SQDIV) ? chp_pkg::PH_MUL
                                                                   : chp_pkg::PH_DIV;
      end
      chp_pkg::PH_MUL: if (steps == chp_pkg::STEP_W'(1)) phase_next = chp_pkg::PH_DIV;
      chp_pkg::PH_DIV: if (steps == chp_pkg::STEP_W'(1)) phase_next = chp_pkg::PH_FIX;
      chp_pkg::PH_FIX: phase_next = chp_pkg::PH_IDLE;
      default: phase_next = chp_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    rsh     = {rem, acc[chp_pkg::PROD_W-1]};
    diffr   = rsh - {1'b0, dvs};
    ge      = rsh >= {1'b0, dvs};
    acc_mul = {acc[chp_pkg::PROD_W-2:0], 1'b0}
            + (mplier[chp_pkg::SUM_W-1] ? chp_pkg::PROD_W'(mcand) : '0);

    // mean: quotient of |num|*256 / d, floored toward minus infinity
    qm   = acc[QM_W-1:0];
    qmag = {1'b0, qm} + (QM_W+1)'(rem != '0);
    if (!neg) begin
      mean_val = (|qm[QM_W-1:chp_pkg::BND_W-1]) ? chp_pkg::BND_MAX
                                                 : qm[chp_pkg::BND_W-1:0];
    end else if ((|qmag[QM_W:chp_pkg::BND_W]) ||
                 (qmag[chp_pkg::BND_W-1] && (|qmag[chp_pkg::BND_W-2:0]))) begin
      mean_val = chp_pkg::BND_MIN;
    end else begin
      mean_val = chp_pkg::BND_W'(0) - qmag[chp_pkg::BND_W-1:0];
    end

    sq_val = (|acc[chp_pkg::PROD_W-1:chp_pkg::COST_W-1]) ? chp_pkg::COST_MAX
                                                          : {1'b0, acc[chp_pkg::COST_W-2:0]};
  end

  always_comb begin
    rsp.done   = done;
    rsp.result = result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= chp_pkg::PH_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == chp_pkg::PH_FIX);
    end

    case (phase)
      chp_pkg::PH_IDLE: begin
        if (req.start) begin
          op  <= req.op;
          dvs <= (req.dvs == '0) ? chp_pkg::COUNT_W'(1) : req.dvs;
          rem <= '0;
          if (req.op == chp_pkg::OP_MEAN) begin
            neg   <= req.opa[chp_pkg::SUM_W-1];
            acc   <= {chp_pkg::mag(req.opa), 8'd0, (chp_pkg::PROD_W-QM_W)'(0)};
            steps <= chp_pkg::STEP_W'(QM_W);
          end else begin
            neg    <= 1'b0;
            mcand  <= req.opa;
            mplier <= req.opa;
            acc    <= '0;
            steps  <= chp_pkg::STEP_W'(chp_pkg::SUM_W);
          end
        end
      end
      chp_pkg::PH_MUL: begin
        acc    <= acc_mul;
        mplier <= {mplier[chp_pkg::SUM_W-2:0], 1'b0};
        steps  <= (steps == chp_pkg::STEP_W'(1)) ? chp_pkg::STEP_W'(chp_pkg::PROD_W)
                                                 : steps - chp_pkg::STEP_W'(1);
      end
      chp_pkg::PH_DIV: begin
        acc   <= {acc[chp_pkg::PROD_W-2:0], ge};
        rem   <= ge ? diffr[chp_pkg::COUNT_W-1:0] : rsh[chp_pkg::COUNT_W-1:0];
        steps <= steps - chp_pkg::STEP_W'(1);
      end
      chp_pkg::PH_FIX: begin
        result <= (op == chp_pkg::OP_MEAN)
                  ? {{(chp_pkg::COST_W-chp_pkg::BND_W){mean_val[chp_pkg::BND_W-1]}}, mean_val}
                  : sq_val;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/changepoint_hull_pruner.sv =====
// Streaming mean-change hull pruner, top level.
// Uses chp_pkg, chp_ram (entry store) and chp_arith (shared divide unit).
//
// Input channel: in_valid / in_stall with one signed Q8.8 sample per word.
// Output channel: out_valid / out_stall carrying best_cost, cost_valid,
// up_entries, down_entries and overflow; one result word per sample.
// Config: cfg_wr_en writes cfg_wr_data into report_cost (reset value 1);
// write it only while no sample is in flight.
// One sample at a time: in_stall is low only while the sequencer is idle.
// Each sample runs on the one shared divide unit: the up and down prune
// passes, each popping entries and then pushing one, plus, with report_cost
// set, a cost scan over both stacks.
// The result sits in an output register; the next sample is taken while it
// waits, and the block only holds at the end of a sample if out_stall is
// still high with the previous word unread.
// Synchronous reset empties both stacks, clears count and sum, drops any
// pending output word and sets report_cost. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module changepoint_hull_pruner (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [chp_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [chp_pkg::COST_W-1:0]   best_cost,
  output logic                                cost_valid,
  output logic [chp_pkg::ENT_W-1:0]           up_entries,
  output logic [chp_pkg::ENT_W-1:0]           down_entries,
  output logic                                overflow,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data
);

  chp_pkg::seq_state_t state, state_next;

  logic                               report_cost;
  logic [chp_pkg::COUNT_W-1:0]        sample_count;
  logic signed [chp_pkg::SUM_W-1:0]   running_sum;
  logic [chp_pkg::ENT_W-1:0]          up_top, down_top;
  logic [chp_pkg::IDX_W-1:0]          up_base, down_base;
  logic                               sel;
  logic [chp_pkg::ENT_W-1:0]          cur;
  logic [chp_pkg::ENT_W-1:0]          walk;
  logic [chp_pkg::COUNT_W-1:0]        e_pos;
  logic signed [chp_pkg::BND_W-1:0]   e_bnd;
  logic signed [chp_pkg::SUM_W-1:0]   e_psum;
  logic signed [chp_pkg::BND_W-1:0]   mu;
  logic [chp_pkg::COST_W-1:0]         t1;
  logic signed [chp_pkg::COST_W-1:0]  best;
  logic                               ovf;

  chp_pkg::arith_req_t req;
  chp_pkg::arith_rsp_t rsp;

  logic                               ram_we;
  logic [chp_pkg::IDX_W:0]            ram_wr_addr, ram_rd_addr;
  logic [chp_pkg::ENTRY_W-1:0]        ram_wr_data, ram_rd_data;
  chp_pkg::entry_t                    rd_entry, wr_entry;
  logic [chp_pkg::IDX_W-1:0]          rd_idx;

  logic signed [chp_pkg::SUM_W-1:0]   sv;
  logic [chp_pkg::ENT_W-1:0]          sel_top;
  logic [chp_pkg::IDX_W-1:0]          sel_base, base_push, wpos;
  logic                               full;
  logic [chp_pkg::ENT_W-1:0]          new_top;
  logic signed [chp_pkg::BND_W-1:0]   rsp_mu;
  logic                               pop_ok;
  logic [chp_pkg::COST_W-1:0]         tsum, tsat;
  logic signed [chp_pkg::COST_W-1:0]  cand_nc, cand_ch;
  logic                               accept, more;

  // segment length n - pos - 1, taken as 1 when it comes out below 1
  function automatic logic [chp_pkg::COUNT_W-1:0] seg_len(
      input logic [chp_pkg::COUNT_W-1:0] n, input logic [chp_pkg::COUNT_W-1:0] pos);
    logic [chp_pkg::COUNT_W:0] d;
    d = {1'b0, n} - {1'b0, pos} - (chp_pkg::COUNT_W+1)'(1);
    if (d[chp_pkg::COUNT_W] || d == '0) return chp_pkg::COUNT_W'(1);
    return d[chp_pkg::COUNT_W-1:0];
  endfunction

  chp_ram #(
    .WIDTH (chp_pkg::ENTRY_W),
    .DEPTH (chp_pkg::RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  chp_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    sv        = sel ? chp_pkg::sat_neg(running_sum) : running_sum;
    sel_top   = sel ? down_top : up_top;
    sel_base  = sel ? down_base : up_base;
    full      = (cur == chp_pkg::ENT_W'(chp_pkg::HULL_DEPTH));
    wpos      = full ? chp_pkg::IDX_W'(chp_pkg::HULL_DEPTH - 1) : cur[chp_pkg::IDX_W-1:0];
    base_push = full ? chp_pkg::phys_idx(sel_base, chp_pkg::IDX_W'(1)) : sel_base;
    new_top   = chp_pkg::ENT_W'(wpos) + chp_pkg::ENT_W'(1);

    rd_entry    = chp_pkg::entry_t'(ram_rd_data);
    wr_entry.pos  = sample_count - chp_pkg::COUNT_W'(1);
    wr_entry.bnd  = mu;
    wr_entry.psum = sv;
    ram_wr_data = wr_entry;
    ram_wr_addr = {sel, chp_pkg::phys_idx(base_push, wpos)};
    ram_rd_addr = {sel, chp_pkg::phys_idx(sel_base, rd_idx)};

    rsp_mu  = rsp.result[chp_pkg::BND_W-1:0];
    pop_ok  = rsp_mu <= e_bnd;
    tsum    = t1 + rsp.result;
    tsat    = tsum[chp_pkg::COST_W-1] ? chp_pkg::COST_MAX : tsum;
    cand_nc = chp_pkg::COST_W'(0) - rsp.result;
    cand_ch = chp_pkg::COST_W'(0) - tsat;
    accept  = in_valid && !in_stall;
    more    = (walk + chp_pkg::ENT_W'(1)) < sel_top;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      chp_pkg::ST_IDLE:      if (in_valid) state_next = chp_pkg::ST_POP_RD;
      chp_pkg::ST_POP_RD:    state_next = (cur == '0) ? chp_pkg::ST_EMPTY_GO
                                                      : chp_pkg::ST_POP_LD;
      chp_pkg::ST_POP_LD:    state_next = chp_pkg::ST_POP_GO;
      chp_pkg::ST_POP_GO:    state_next = chp_pkg::ST_POP_DIV;
      chp_pkg::ST_POP_DIV: begin
        if (rsp.done) state_next = pop_ok ? chp_pkg::ST_POP_RD : chp_pkg::ST_PUSH;
      end
      chp_pkg::ST_EMPTY_GO:  state_next = chp_pkg::ST_EMPTY_DIV;
      chp_pkg::ST_EMPTY_DIV: if (rsp.done) state_next = chp_pkg::ST_PUSH;
      chp_pkg::ST_PUSH: begin
        if (!sel) state_next = chp_pkg::ST_POP_RD;
        else if (report_cost) state_next = chp_pkg::ST_NC_GO;
        else state_next = chp_pkg::ST_DONE;
      end
      chp_pkg::ST_NC_GO:     state_next = chp_pkg::ST_NC_WAIT;
      chp_pkg::ST_NC_WAIT:   if (rsp.done) state_next = chp_pkg::ST_C_RD;
      chp_pkg::ST_C_RD: begin
        if (more) state_next = chp_pkg::ST_C_LD;
        else if (!sel) state_next = chp_pkg::ST_NC_GO;
        else state_next = chp_pkg::ST_DONE;
      end
      chp_pkg::ST_C_LD:      state_next = chp_pkg::ST_C_T1GO;
      chp_pkg::ST_C_T1GO:    state_next = chp_pkg::ST_C_T1;
      chp_pkg::ST_C_T1:      if (rsp.done) state_next = chp_pkg::ST_C_T2GO;
      chp_pkg::ST_C_T2GO:    state_next = chp_pkg::ST_C_T2;
      chp_pkg::ST_C_T2:      if (rsp.done) state_next = chp_pkg::ST_C_RD;
      chp_pkg::ST_DONE:      if (!(out_valid && out_stall)) state_next = chp_pkg::ST_IDLE;
      default:               state_next = chp_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = (state != chp_pkg::ST_IDLE);
    ram_we    = (state == chp_pkg::ST_PUSH);
    rd_idx    = walk[chp_pkg::IDX_W-1:0];
    req.start = 1'b0;
    req.op    = chp_pkg::OP_MEAN;
    req.opa   = sv;
    req.dvs   = sample_count;
    case (state)
      chp_pkg::ST_POP_RD: rd_idx = chp_pkg::IDX_W'(cur - chp_pkg::ENT_W'(1));
      chp_pkg::ST_POP_GO: begin
        req.start = 1'b1;
        req.opa   = chp_pkg::sat_sub(sv, e_psum);
        req.dvs   = seg_len(sample_count, e_pos);
      end
      chp_pkg::ST_EMPTY_GO: req.start = 1'b1;
      chp_pkg::ST_NC_GO: begin
        req.start = 1'b1;
        req.op    = chp_pkg::OP_SQDIV;
        req.opa   = chp_pkg::mag(sv);
      end
      chp_pkg::ST_C_T1GO: begin
        req.start = 1'b1;
        req.op    = chp_pkg::OP_SQDIV;
        req.opa   = chp_pkg::mag(e_psum);
        req.dvs   = e_pos + chp_pkg::COUNT_W'(1);
      end
      chp_pkg::ST_C_T2GO: begin
        req.start = 1'b1;
        req.op    = chp_pkg::OP_SQDIV;
        req.opa   = chp_pkg::mag(chp_pkg::sat_sub(sv, e_psum));
        req.dvs   = seg_len(sample_count, e_pos);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= chp_pkg::ST_IDLE;
      report_cost  <= 1'b1;
      sample_count <= '0;
      running_sum  <= '0;
      up_top       <= '0;
      down_top     <= '0;
      up_base      <= '0;
      down_base    <= '0;
      sel          <= 1'b0;
      cur          <= '0;
      walk         <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) report_cost <= cfg_wr_data;
      // a finished sample loads the output register once the old word is gone
      if ((state == chp_pkg::ST_DONE) && !(out_valid && out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        chp_pkg::ST_IDLE: begin
          if (accept) begin
            if (sample_count != '1) sample_count <= sample_count + chp_pkg::COUNT_W'(1);
            running_sum <= chp_pkg::sat_add(running_sum, chp_pkg::SUM_W'(sample));
            sel         <= 1'b0;
            cur         <= up_top;
          end
        end
        chp_pkg::ST_POP_DIV: if (rsp.done && pop_ok) cur <= cur - chp_pkg::ENT_W'(1);
        chp_pkg::ST_PUSH: begin
          if (sel) begin
            down_top  <= new_top;
            down_base <= base_push;
            sel       <= 1'b0;
          end else begin
            up_top    <= new_top;
            up_base   <= base_push;
            sel       <= 1'b1;
            cur       <= down_top;
          end
          walk <= '0;
        end
        chp_pkg::ST_C_RD: begin
          if (!more && !sel) begin
            sel  <= 1'b1;
            walk <= '0;
          end
        end
        chp_pkg::ST_C_T2: if (rsp.done) walk <= walk + chp_pkg::ENT_W'(1);
        default: ;
      endcase
    end

    // payload registers
    case (state)
      chp_pkg::ST_IDLE: begin
        ovf  <= 1'b0;
        best <= '0;
      end
      chp_pkg::ST_POP_LD, chp_pkg::ST_C_LD: begin
        e_pos  <= rd_entry.pos;
        e_bnd  <= rd_entry.bnd;
        e_psum <= rd_entry.psum;
      end
      chp_pkg::ST_POP_DIV, chp_pkg::ST_EMPTY_DIV: if (rsp.done) mu <= rsp_mu;
      chp_pkg::ST_PUSH: if (full) ovf <= 1'b1;
      chp_pkg::ST_NC_WAIT: if (rsp.done && (cand_nc < best)) best <= cand_nc;
      chp_pkg::ST_C_T1: if (rsp.done) t1 <= rsp.result;
      chp_pkg::ST_C_T2: if (rsp.done && (cand_ch < best)) best <= cand_ch;
      chp_pkg::ST_DONE: begin
        if (!(out_valid && out_stall)) begin
          best_cost    <= report_cost ? best : '0;
          cost_valid   <= report_cost;
          up_entries   <= up_top;
          down_entries <= down_top;
          overflow     <= ovf;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/chp_checker.sv =====
// Port-level checks for changepoint_hull_pruner, attached with bind.
// Uses assert_macros.svh and chp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module chp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [chp_pkg::COST_W-1:0] best_cost,
  input logic                              cost_valid,
  input logic [chp_pkg::ENT_W-1:0]         up_entries,
  input logic [chp_pkg::ENT_W-1:0]         down_entries,
  input logic                              overflow
);

  `CHP_ASSERT_CLK(a_reset_clean, clk, rst |=> (!out_valid && !in_stall), "reset left work pending")
  `CHP_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(best_cost)), "stalled word changed")
  `CHP_ASSERT(a_entries_range, clk, rst, out_valid |-> (up_entries != 0 && down_entries != 0 && up_entries <= chp_pkg::HULL_DEPTH && down_entries <= chp_pkg::HULL_DEPTH), "stack count out of range")
  `CHP_ASSERT(a_ovf_full, clk, rst, (out_valid && overflow) |-> (up_entries == chp_pkg::HULL_DEPTH || down_entries == chp_pkg::HULL_DEPTH), "overflow without a full stack")
  `CHP_ASSERT(a_cost_sign, clk, rst, out_valid |-> ((best_cost[chp_pkg::COST_W-1] || best_cost == 0) && (cost_valid || best_cost == 0)), "cost positive or set while off")

endmodule

bind changepoint_hull_pruner chp_checker u_chp_checker (.*);

`default_nettype wire
